### rtl/sharpen_3x3_with_fallback_assert.svh
// Assertion macros shared by the sharpening filter RTL.
// Each macro is one concurrent assertion on a clock, with an active-low reset disable.
`ifndef SHARPEN_3X3_WITH_FALLBACK_ASSERT_SVH
`define SHARPEN_3X3_WITH_FALLBACK_ASSERT_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define SH3_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sh3 assertion failed");
// Consequent must hold in the cycle after the antecedent.
`define SH3_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sh3 assertion failed");
`else
`define SH3_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define SH3_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/sh3_pkg.sv
// Package for the 3x3 sharpening filter: widths, reset values, register indexes, types.
// No dependencies; used by sh3_linebuf and sharpen_3x3_with_fallback.
`timescale 1ns / 1ps

package sh3_pkg;

    // Pixel and configuration widths.
    localparam int PIX_W       = 8;
    localparam int CFG_W       = 11;
    localparam int CFG_ADDR_W  = 1;

    // Image geometry limits and reset values.
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 1024;
    localparam int MIN_SIZE      = 3;
    localparam int ROW_W         = $clog2(MAX_HEIGHT);
    localparam int HGT_W         = ROW_W + 1;
    localparam logic [CFG_W-1:0] WIDTH_RST  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RST = CFG_W'(480);

    // Register indexes on the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // Kernel sum: 5*C minus four neighbors spans -1020..1275.
    localparam int SUM_W = 12;

    // Output queue.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

    // One result word.
    typedef struct packed {
        logic             last_of_frame;
        logic             fell_back;
        logic [PIX_W-1:0] pixel_out;
    } t_result;

endpackage

### rtl/sh3_linebuf.sv
// Two line buffers (rows r-1 and r-2) with registered reads and a same-column bypass.
// Depends on sh3_pkg and sharpen_3x3_with_fallback_assert.svh.
`timescale 1ns / 1ps
`include "sharpen_3x3_with_fallback_assert.svh"

module sh3_linebuf #(
    parameter int MAX_WIDTH = sh3_pkg::MAX_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_col,
    input  logic [sh3_pkg::PIX_W-1:0]   i_px,
    output logic [sh3_pkg::PIX_W-1:0]   o_up,
    output logic [sh3_pkg::PIX_W-1:0]   o_lo
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [sh3_pkg::PIX_W-1:0] mem_upper [MAX_WIDTH];
    logic [sh3_pkg::PIX_W-1:0] mem_lower [MAX_WIDTH];

    logic [sh3_pkg::PIX_W-1:0] r_rd_up;
    logic [sh3_pkg::PIX_W-1:0] r_rd_lo;
    logic [sh3_pkg::PIX_W-1:0] r_byp_data;
    logic [CW-1:0]             r_col;
    logic                      r_valid;
    logic                      r_byp;
    logic                      n_byp;

    // A new read hits the column whose upper entry is being written this cycle.
    assign n_byp = i_rd_en && r_valid && (r_col == i_col);

    // Read both rows at the new column; the new pixel goes into the lower row at once,
    // the old lower entry moves up in the following cycle.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_up        <= mem_upper[i_col];
            r_rd_lo        <= mem_lower[i_col];
            mem_lower[i_col] <= i_px;
        end
        if (r_valid) begin
            mem_upper[r_col] <= r_rd_lo;
        end
    end

    // Stage bookkeeping for the delayed upper write and the bypass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_byp   <= 1'b0;
        end else begin
            r_valid <= i_rd_en;
            r_byp   <= n_byp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_col <= i_col;
        end
        r_byp_data <= r_rd_lo;
    end

    assign o_up = r_byp ? r_byp_data : r_rd_up;
    assign o_lo = r_rd_lo;

    `SH3_ASSERT_SAME(a_byp_needs_stage, i_clk, i_rst_n, r_byp, r_valid)
    `SH3_ASSERT_NEXT(a_stage_follows_read, i_clk, i_rst_n, i_rd_en, r_valid)

endmodule

### rtl/sharpen_3x3_with_fallback.sv
// Results: the word for the pixel one row and one column past its center passes the first-stage
// registers and the line buffer read, then enters the output queue; borders give none.
// Throughput: one pixel per clock through a two-stage pipe (line buffer read, then window and
// kernel); s_axis_tready drops while the queue plus the word in flight holds four words.
// Reset (synchronous, active low) clears counters, window, queue and restores 640x480;
// line buffer contents are not cleared.
`timescale 1ns / 1ps
`include "sharpen_3x3_with_fallback_assert.svh"

module sharpen_3x3_with_fallback #(
    parameter int MAX_WIDTH = sh3_pkg::MAX_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration write channel.
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [sh3_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [sh3_pkg::CFG_W-1:0]       i_cfg_data,
    // Pixel input stream.
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [sh3_pkg::PIX_W-1:0]       s_axis_tdata,   // [7:0] pixel_in
    input  logic                            s_axis_tuser,   // [0] frame_start
    // Result stream.
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [sh3_pkg::PIX_W-1:0]       m_axis_tdata,   // [7:0] pixel_out
    output logic                            m_axis_tuser,   // [0] fell_back
    output logic                            m_axis_tlast    // last_of_frame
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = (CW + 1 > sh3_pkg::CFG_W) ? CW + 1 : sh3_pkg::CFG_W;
    localparam int RW = sh3_pkg::ROW_W;
    localparam int HW = sh3_pkg::HGT_W;
    localparam int PW = sh3_pkg::PIX_W;
    localparam int SW = sh3_pkg::SUM_W;

    // Configuration registers.
    logic [sh3_pkg::CFG_W-1:0] r_image_width;
    logic [sh3_pkg::CFG_W-1:0] r_image_height;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= sh3_pkg::WIDTH_RST;
            r_image_height <= sh3_pkg::HEIGHT_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                sh3_pkg::REG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data;
                sh3_pkg::REG_IMAGE_HEIGHT: r_image_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the geometry into the supported range.
    logic [WW-1:0] w_cfg_ext;
    logic [WW-1:0] w_clamp;
    logic [HW-1:0] h_clamp;

    assign w_cfg_ext = WW'(r_image_width);

    always_comb begin
        if (w_cfg_ext < WW'(sh3_pkg::MIN_SIZE)) begin
            w_clamp = WW'(sh3_pkg::MIN_SIZE);
        end else if (w_cfg_ext > WW'(MAX_WIDTH)) begin
            w_clamp = WW'(MAX_WIDTH);
        end else begin
            w_clamp = w_cfg_ext;
        end
        if (r_image_height < sh3_pkg::CFG_W'(sh3_pkg::MIN_SIZE)) begin
            h_clamp = HW'(sh3_pkg::MIN_SIZE);
        end else if (r_image_height > sh3_pkg::CFG_W'(sh3_pkg::MAX_HEIGHT)) begin
            h_clamp = HW'(sh3_pkg::MAX_HEIGHT);
        end else begin
            h_clamp = HW'(r_image_height);
        end
    end

    // Position of the incoming pixel and the result it triggers.
    logic          acc;
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] col_cur;
    logic [RW-1:0] row_cur;
    logic [WW-1:0] col_ext;
    logic [WW-1:0] col_inc;
    logic [HW-1:0] row_ext;
    logic [HW-1:0] row_inc;
    logic [CW-1:0] n_col;
    logic [RW-1:0] n_row;
    logic          emit;
    logic          last;

    assign acc     = s_axis_tvalid && s_axis_tready;
    assign col_cur = s_axis_tuser ? '0 : r_col;
    assign row_cur = s_axis_tuser ? '0 : r_row;
    assign col_ext = WW'(col_cur);
    assign col_inc = col_ext + WW'(1);
    assign row_ext = HW'(row_cur);
    assign row_inc = row_ext + HW'(1);

    assign emit = (col_ext < w_clamp) && (row_ext < h_clamp)
               && (col_ext >= WW'(2)) && (row_ext >= HW'(2));
    assign last = (row_ext == h_clamp - HW'(1)) && (col_ext == w_clamp - WW'(1));

    // Counters wrap at the row end and at the frame end.
    always_comb begin
        n_row = row_cur;
        n_col = CW'(col_inc);
        if (col_inc >= w_clamp) begin
            n_col = '0;
            n_row = (row_inc >= h_clamp) ? '0 : RW'(row_inc);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (acc) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // First stage: pixel and its result flags wait for the line buffer read.
    logic          r_a_valid;
    logic          r_a_emit;
    logic          r_a_last;
    logic [PW-1:0] r_a_px;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else begin
            r_a_valid <= acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_emit <= emit;
            r_a_last <= last;
            r_a_px   <= s_axis_tdata;
        end
    end

    logic [PW-1:0] lb_up;
    logic [PW-1:0] lb_lo;

    sh3_linebuf #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_linebuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd_en (acc),
        .i_col   (col_cur),
        .i_px    (s_axis_tdata),
        .o_up    (lb_up),
        .o_lo    (lb_lo)
    );

    // Window columns that the kernel touches: newest of the top row, newest and
    // previous of the middle row, newest of the bottom row.
    logic [PW-1:0] r_up_new;
    logic [PW-1:0] r_mid_new;
    logic [PW-1:0] r_mid_prev;
    logic [PW-1:0] r_low_new;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_new   <= '0;
            r_mid_new  <= '0;
            r_mid_prev <= '0;
            r_low_new  <= '0;
        end else if (r_a_valid) begin
            r_up_new   <= lb_up;
            r_mid_new  <= lb_lo;
            r_mid_prev <= r_mid_new;
            r_low_new  <= r_a_px;
        end
    end

    // Kernel on the shifted window: center is the previous middle-row pixel.
    logic [SW-1:0]          c_ext;
    logic [SW-1:0]          sum;
    logic                   fb;
    sh3_pkg::t_result       res;

    assign c_ext = SW'(r_mid_new);
    assign sum   = (c_ext << 2) + c_ext - SW'(r_up_new) - SW'(r_low_new)
                 - SW'(r_mid_prev) - SW'(lb_lo);
    assign fb    = sum[SW-1] | (|sum[SW-2:PW]);

    always_comb begin
        res.last_of_frame = r_a_last;
        res.fell_back     = fb;
        res.pixel_out     = fb ? r_mid_new : sum[PW-1:0];
    end

    // Output queue; input is held off when in-flight results could overflow it.
    localparam logic [sh3_pkg::FIFO_CNT_W-1:0] QUEUE_FULL =
        sh3_pkg::FIFO_CNT_W'(sh3_pkg::FIFO_DEPTH);

    sh3_pkg::t_result                 r_fifo [sh3_pkg::FIFO_DEPTH];
    logic [sh3_pkg::FIFO_PTR_W-1:0]   r_wr_ptr;
    logic [sh3_pkg::FIFO_PTR_W-1:0]   r_rd_ptr;
    logic [sh3_pkg::FIFO_CNT_W-1:0]   r_count;
    logic [sh3_pkg::FIFO_CNT_W-1:0]   pending;
    logic                             push;
    logic                             pop;

    assign push    = r_a_valid && r_a_emit;
    assign pop     = m_axis_tvalid && m_axis_tready;
    assign pending = r_count + sh3_pkg::FIFO_CNT_W'(push);
    assign s_axis_tready = pending < QUEUE_FULL;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= r_wr_ptr + sh3_pkg::FIFO_PTR_W'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + sh3_pkg::FIFO_PTR_W'(1);
            end
            r_count <= r_count + sh3_pkg::FIFO_CNT_W'(push) - sh3_pkg::FIFO_CNT_W'(pop);
        end
    end

    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = r_fifo[r_rd_ptr].pixel_out;
    assign m_axis_tuser  = r_fifo[r_rd_ptr].fell_back;
    assign m_axis_tlast  = r_fifo[r_rd_ptr].last_of_frame;

    `SH3_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, push && !pop, r_count < QUEUE_FULL)
    `SH3_ASSERT_SAME(a_credit_bound, i_clk, i_rst_n, 1'b1, pending <= QUEUE_FULL)
    `SH3_ASSERT_SAME(a_last_is_result, i_clk, i_rst_n, r_a_valid && r_a_last, r_a_emit)
    `SH3_ASSERT_NEXT(a_frame_restart, i_clk, i_rst_n, acc && s_axis_tuser, (r_col == CW'(1)) && (r_row == '0))

endmodule

### tb/tb_sharpen_3x3_with_fallback.sv
// Self-checking testbench for the 3x3 sharpening filter with out-of-range fallback.
// Depends only on sh3_pkg and the sharpen_3x3_with_fallback RTL; no files or arguments.
`timescale 1ns / 1ps

module tb_sharpen_3x3_with_fallback;

    localparam int LINE_MAX      = sh3_pkg::MAX_WIDTH_DEF;
    localparam int RANDOM_PIXELS = 850;
    localparam int WIDE_PIXELS   = 200;
    localparam int TALL_ROWS     = 64;
    localparam int CYCLE_LIMIT   = 1_000_000;

    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_cfg_valid   = 1'b0;
    logic                           o_cfg_ready;
    logic [sh3_pkg::CFG_ADDR_W-1:0] i_cfg_addr    = sh3_pkg::REG_IMAGE_WIDTH;
    logic [sh3_pkg::CFG_W-1:0]      i_cfg_data    = '0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [sh3_pkg::PIX_W-1:0]      s_axis_tdata  = '0;   // [7:0] pixel_in
    logic                           s_axis_tuser  = 1'b0; // [0] frame_start
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [sh3_pkg::PIX_W-1:0]      m_axis_tdata;         // [7:0] pixel_out
    logic                           m_axis_tuser;         // [0] fell_back
    logic                           m_axis_tlast;         // last_of_frame

    // Shadow of the block: registers, line buffers, window and position.
    logic [sh3_pkg::CFG_W-1:0] width_reg  = sh3_pkg::WIDTH_RST;
    logic [sh3_pkg::CFG_W-1:0] height_reg = sh3_pkg::HEIGHT_RST;
    logic [sh3_pkg::PIX_W-1:0] upper_line [LINE_MAX];
    logic [sh3_pkg::PIX_W-1:0] lower_line [LINE_MAX];
    logic [sh3_pkg::PIX_W-1:0] win [9];
    int unsigned               col_pos = 0;
    int unsigned               row_pos = 0;
    sh3_pkg::t_result          sharpened_q [$];

    // Run bookkeeping.
    bit idling_on      = 1'b1;
    int rx_stall_left  = 0;
    int cycles         = 0;
    int mismatches     = 0;
    int pixels_sent    = 0;
    int results_seen   = 0;
    int fallbacks_seen = 0;
    int frame_ends     = 0;
    int settings_used  = 0;
    int pixel_base     = 128;

    sharpen_3x3_with_fallback #(
        .MAX_WIDTH(LINE_MAX)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #1 i_clk = ~i_clk;

    initial begin
        for (int i = 0; i < LINE_MAX; i++) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) begin
            win[i] = '0;
        end
    end

    // Guard against a hung run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("cycle limit of %0d reached with %0d results outstanding",
                     CYCLE_LIMIT, sharpened_q.size());
            $display("status: fail");
            $finish;
        end
    end

    // Result receiver: random stall bursts while idling is enabled.
    always @(posedge i_clk) begin
        if (rx_stall_left != 0) begin
            rx_stall_left--;
            m_axis_tready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 9) == 0) begin
            rx_stall_left = $urandom_range(1, 12) - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // Compare every accepted result word with the oldest expectation.
    always @(posedge i_clk) begin
        sh3_pkg::t_result got;
        sh3_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.pixel_out     = m_axis_tdata;
            got.fell_back     = m_axis_tuser;
            got.last_of_frame = m_axis_tlast;
            results_seen++;
            if (got.fell_back === 1'b1) fallbacks_seen++;
            if (got.last_of_frame === 1'b1) frame_ends++;
            if (sharpened_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("cycle %0d: unexpected word pixel_out=%0d fell_back=%0b last=%0b",
                             cycles, got.pixel_out, got.fell_back, got.last_of_frame);
                end
            end else begin
                want = sharpened_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("cycle %0d: expected pixel_out=%0d fell_back=%0b last=%0b,",
                                 cycles, want.pixel_out, want.fell_back,
                                 want.last_of_frame);
                        $display("    got pixel_out=%0d fell_back=%0b last=%0b",
                                 got.pixel_out, got.fell_back, got.last_of_frame);
                    end
                end
            end
        end
    end

    function automatic int unsigned clamp_dim(logic [sh3_pkg::CFG_W-1:0] v, int unsigned hi);
        if (v < sh3_pkg::MIN_SIZE) return sh3_pkg::MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    // Advance the shadow by one accepted pixel and queue the sharpened word it yields.
    task automatic predict_pixel(input logic [sh3_pkg::PIX_W-1:0] pix, input logic fs);
        int unsigned w;
        int unsigned h;
        int unsigned col;
        int unsigned row;
        logic [sh3_pkg::PIX_W-1:0] up;
        logic [sh3_pkg::PIX_W-1:0] lo;
        int sum;
        sh3_pkg::t_result word;
        w  = clamp_dim(width_reg, LINE_MAX);
        h  = clamp_dim(height_reg, sh3_pkg::MAX_HEIGHT);
        up = '0;
        lo = '0;
        if (fs) begin
            col_pos = 0;
            row_pos = 0;
        end
        col = col_pos;
        row = row_pos;
        if (col < LINE_MAX) begin
            up = upper_line[col];
            lo = lower_line[col];
            upper_line[col] = lo;
            lower_line[col] = pix;
        end
        // Shift the window left; the right column takes the two buffered rows and the new pixel.
        for (int i = 0; i < 3; i++) begin
            win[i * 3]     = win[i * 3 + 1];
            win[i * 3 + 1] = win[i * 3 + 2];
        end
        win[2] = up;
        win[5] = lo;
        win[8] = pix;
        if (col >= 2 && row >= 2 && col < w && row < h) begin
            sum = 5 * int'(win[4]) - int'(win[1]) - int'(win[7]) - int'(win[3])
                  - int'(win[5]);
            word.fell_back     = (sum < 0) || (sum > 255);
            word.pixel_out     = word.fell_back ? win[4] : sum[7:0];
            word.last_of_frame = (row == h - 1) && (col == w - 1);
            sharpened_q.push_back(word);
        end
        if (col + 1 >= w) begin
            col_pos = 0;
            row_pos = (row + 1 >= h) ? 0 : row + 1;
        end else begin
            col_pos = col + 1;
        end
    endtask

    // Pixel content: uniform, smooth drift, saturated extremes, or drift with spikes.
    function automatic logic [sh3_pkg::PIX_W-1:0] next_pixel(int mode);
        int v;
        int d;
        d = $urandom_range(0, 6);
        pixel_base = pixel_base + d - 3;
        if (pixel_base < 0) pixel_base = 0;
        if (pixel_base > 255) pixel_base = 255;
        d = $urandom_range(0, 10);
        case (mode)
            0: v = $urandom_range(0, 255);
            1: v = pixel_base + d / 2 - 2;
            2: begin
                case ($urandom_range(0, 3))
                    0: v = 0;
                    1: v = 255;
                    2: v = $urandom_range(0, 3);
                    default: v = $urandom_range(252, 255);
                endcase
            end
            default: v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                                     : pixel_base + d - 5;
        endcase
        if (v < 0) v = 0;
        if (v > 255) v = 255;
        return v[7:0];
    endfunction

    // Offer one pixel word, with an optional idle burst first.
    task automatic send_pixel(input logic [sh3_pkg::PIX_W-1:0] pix, input logic fs);
        if (idling_on && $urandom_range(0, 7) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pix;
        s_axis_tuser  <= fs;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_pixel(pix, fs);
        pixels_sent++;
    endtask

    // A run of pixels; the first takes fs_first. At a frame boundary frame_start is random; elsewhere it restarts
    // the frame with odds of one in restart_odds (zero means never).
    task automatic send_run(input int n, input int mode, input logic fs_first,
                            input int restart_odds);
        logic fs;
        for (int i = 0; i < n; i++) begin
            if (i == 0) fs = fs_first;
            else if (col_pos == 0 && row_pos == 0) fs = $urandom_range(0, 1);
            else if (restart_odds > 0) fs = ($urandom_range(1, restart_odds) == 1);
            else fs = 1'b0;
            send_pixel(next_pixel(mode), fs);
        end
    endtask

    // Stop sending until every expected word has arrived and the pipe has settled.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (sharpened_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [sh3_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [sh3_pkg::CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == sh3_pkg::REG_IMAGE_WIDTH) width_reg = val;
        else if (idx == sh3_pkg::REG_IMAGE_HEIGHT) height_reg = val;
    endtask

    task automatic set_geometry(input logic [sh3_pkg::CFG_W-1:0] w,
                                input logic [sh3_pkg::CFG_W-1:0] h,
                                input bit do_w, input bit do_h);
        wait_drained();
        if (do_w) write_reg(sh3_pkg::REG_IMAGE_WIDTH, w);
        if (do_h) write_reg(sh3_pkg::REG_IMAGE_HEIGHT, h);
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [sh3_pkg::CFG_W-1:0] pick_dim(int unsigned common_hi);
        case ($urandom_range(0, 9))
            0: return sh3_pkg::CFG_W'($urandom_range(0, sh3_pkg::MIN_SIZE - 1));
            1: return sh3_pkg::CFG_W'($urandom_range(common_hi + 1, 2047));
            default: return sh3_pkg::CFG_W'($urandom_range(sh3_pkg::MIN_SIZE, common_hi));
        endcase
    endfunction

    // Hand-built frames hitting sums of exactly 255 and 0 plus both fallback directions.
    task automatic test_kernel_corners();
        logic [sh3_pkg::PIX_W-1:0] wide5 [15];
        logic [sh3_pkg::PIX_W-1:0] tiny3 [9];
        wide5 = '{8'd255, 8'd0,   8'd0,   8'd255, 8'd0,
                  8'd0,   8'd102, 8'd255, 8'd0,   8'd255,
                  8'd128, 8'd0,   8'd0,   8'd255, 8'd1};
        tiny3 = '{8'd0, 8'd5, 8'd0,
                  8'd0, 8'd1, 8'd0,
                  8'd0, 8'd0, 8'd0};
        set_geometry(sh3_pkg::CFG_W'(5), sh3_pkg::CFG_W'(3), 1'b1, 1'b1);
        for (int i = 0; i < 15; i++) send_pixel(wide5[i], i == 0);
        set_geometry(sh3_pkg::CFG_W'(3), sh3_pkg::CFG_W'(3), 1'b1, 1'b1);
        for (int i = 0; i < 9; i++) send_pixel(tiny3[i], i == 0);
    endtask

    // Restart mid-frame, then a full frame, then one led by frame_start and one reached by wrapping alone.
    task automatic test_frame_restart();
        set_geometry(sh3_pkg::CFG_W'(6), sh3_pkg::CFG_W'(4), 1'b1, 1'b1);
        send_run(10, 3, 1'b1, 0);
        send_pixel(next_pixel(3), 1'b1);
        send_run(23, 3, 1'b0, 0);
        send_pixel(next_pixel(0), 1'b1);
        for (int i = 1; i < 48; i++) send_pixel(next_pixel(0), 1'b0);
    endtask

    // Lower the width while the column position is already past it.
    task automatic test_width_lowered();
        set_geometry(sh3_pkg::CFG_W'(10), sh3_pkg::CFG_W'(6), 1'b1, 1'b1);
        send_run(27, 1, 1'b1, 0);
        set_geometry(sh3_pkg::CFG_W'(5), '0, 1'b1, 1'b0);
        for (int i = 0; i < 16; i++) send_pixel(next_pixel(3), 1'b0);
    endtask

    // Width register over range and height below range; the start of the first row of the
    // widest line must pass without any word.
    task automatic test_wide_frame();
        set_geometry(sh3_pkg::CFG_W'(2047), sh3_pkg::CFG_W'(1), 1'b1, 1'b1);
        send_run(WIDE_PIXELS, 3, 1'b1, 0);
    endtask

    // Narrowest line with the tallest height, over the first rows of the frame.
    task automatic test_tall_frame();
        set_geometry(sh3_pkg::CFG_W'(2), sh3_pkg::CFG_W'(sh3_pkg::MAX_HEIGHT), 1'b1, 1'b1);
        send_run(3 * TALL_ROWS, 3, 1'b1, 0);
    endtask

    // Random geometries and content; the final stretch runs without idling.
    task automatic test_random_stream();
        int sent;
        int n;
        int split;
        int mode;
        int pick;
        logic fs_first;
        logic [sh3_pkg::CFG_W-1:0] new_w;
        logic [sh3_pkg::CFG_W-1:0] new_h;
        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            idling_on = (sent < RANDOM_PIXELS * 4 / 5) && ($urandom_range(0, 3) != 0);
            pick      = $urandom_range(0, 3);
            new_w     = pick_dim(16);
            new_h     = pick_dim(8);
            fs_first  = $urandom_range(0, 1);
            if (pick != 0) begin
                set_geometry(new_w, new_h, pick != 2, pick != 1);
            end
            // A new width needs fresh line buffer rows before any result.
            if (pick == 1 || pick == 3) fs_first = 1'b1;
            mode = $urandom_range(0, 3);
            n = clamp_dim(width_reg, LINE_MAX) * clamp_dim(height_reg, sh3_pkg::MAX_HEIGHT)
                * $urandom_range(1, 2) + $urandom_range(0, 8);
            if (n > 240) n = $urandom_range(120, 240);
            if ($urandom_range(0, 3) == 0) begin
                split = $urandom_range(1, n - 1);
                send_run(split, mode, fs_first, 100);
                wait_drained();
                send_run(n - split, mode, 1'b0, 100);
            end else begin
                send_run(n, mode, fs_first, 100);
            end
            sent += n;
        end
        idling_on = 1'b0;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_kernel_corners();
        test_frame_restart();
        test_width_lowered();
        test_wide_frame();
        test_tall_frame();
        test_random_stream();
        wait_drained();
        repeat (16) @(posedge i_clk);
        $display("Sent %0d pixels under %0d register settings in %0d cycles.",
                 pixels_sent, settings_used, cycles);
        $display("Checked %0d results: %0d fallbacks, %0d frame ends, %0d mismatches.",
                 results_seen, fallbacks_seen, frame_ends, mismatches);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
